@@ src/nmfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package nmfl_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT = 1024;

   // register reset values
   localparam logic [10:0] WIDTH_RESET    = 11'd1024;
   localparam logic [15:0] HEIGHT_RESET   = 16'd1024;
   localparam logic [2:0]  CHANNELS_RESET = 3'd3;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_CHANNELS = 2'd2;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic reading;
   } back_status_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_READ,
      B_SQUARE,
      B_SUM,
      B_RHS,
      B_RHS_SUM,
      B_K,
      B_MUL,
      B_CMP,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

@@ src/normal_map_from_luminance.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Normal map from a luminance height field. Pixels arrive in raster order on
// the req_ channel; each becomes a Q8.8 luminance held in a two-line circular
// store, and each result carries the normal bytes for the pixel width+1
// requests back, with neighbours clamped at the frame edges. Drain requests
// (req_drain high) after the frame's last pixel flush the remaining results.
// A pixel request can be taken while the back end is still searching for
// an earlier result. For each result the back end makes four neighbour
// reads from the single read port of the line store, then runs an exact
// 8-step bit search, from the top bit down, for each of the 3 components
// in turn on one shared pair of multipliers. Pixels are held off while
// the back end still has results queued or is reading neighbours; drain
// requests queue up to two deep. Registers (APB, byte address 4*index):
// image_width, image_height, channel_count. Any register write restarts the
// frame; writes belong to idle periods only.
module normal_map_from_luminance #(
   parameter int unsigned MAX_WIDTH = nmfl_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel requests
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_chan0,
   input  wire logic [7:0]  req_chan1,
   input  wire logic [7:0]  req_chan2,
   input  wire logic        req_drain,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_normal_x,
   output logic [7:0]       rsp_normal_y,
   output logic [7:0]       rsp_normal_z,
   output logic             rsp_frame_end,
   // configuration
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import nmfl_pkg::*;

   localparam int unsigned DEPTH  = 2 * MAX_WIDTH + 2;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned JOB_W  = 4 * ADDR_W + 1;

   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  channels_ff;
   logic        cfg_write, restart;

   queue_status_type  qstat;
   back_status_type   bstat;
   logic              job_push, job_pop;
   logic [JOB_W-1:0]  job_in, job_head;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;

   // APB: pready always high, register index in paddr[3:2]
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign restart   = cfg_write && (paddr[3:2] inside {REG_WIDTH, REG_HEIGHT, REG_CHANNELS});

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         channels_ff <= CHANNELS_RESET;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_WIDTH:    width_ff    <= pwdata[10:0];
            REG_HEIGHT:   height_ff   <= pwdata[15:0];
            REG_CHANNELS: channels_ff <= pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:    prdata = {21'd0, width_ff};
         REG_HEIGHT:   prdata = {16'd0, height_ff};
         REG_CHANNELS: prdata = {29'd0, channels_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // front: luminance, counters, neighbour addresses
   nmfl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .image_width   (width_ff),
      .image_height  (height_ff),
      .channel_count (channels_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_chan0     (req_chan0),
      .req_chan1     (req_chan1),
      .req_chan2     (req_chan2),
      .req_drain     (req_drain),
      .qstat         (qstat),
      .bstat         (bstat),
      .job_push      (job_push),
      .job_data      (job_in),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata)
   );

   // queue of pending result jobs
   nmfl_queue #(.DATA_W(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset || restart),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .head      (job_head),
      .status    (qstat)
   );

   // back: line store, neighbour reads, normal search, output register
   nmfl_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .qstat         (qstat),
      .job_data      (job_head),
      .job_pop       (job_pop),
      .bstat         (bstat),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_normal_x  (rsp_normal_x),
      .rsp_normal_y  (rsp_normal_y),
      .rsp_normal_z  (rsp_normal_z),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

@@ src/nmfl_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nmfl_queue #(
   parameter int unsigned DATA_W = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [DATA_W-1:0]         push_data,
   input  wire logic                      pop,
   output logic [DATA_W-1:0]              head,
   output nmfl_pkg::queue_status_type     status
);
   import nmfl_pkg::*;

   logic [DATA_W-1:0] slot0_ff, slot0_in;
   logic [DATA_W-1:0] slot1_ff, slot1_in;
   logic [1:0]        count_ff, count_in;

   // two-entry queue, head always in slot0
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) slot0_in = push_data;
            else slot1_in = push_data;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) count_ff <= 2'd0;
      else count_ff <= count_in;
   end

   assign head         = slot0_ff;
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule
`default_nettype wire

@@ src/nmfl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nmfl_front #(
   parameter int unsigned MAX_WIDTH = nmfl_pkg::MAX_WIDTH_DEFAULT,
   localparam int unsigned DEPTH  = 2 * MAX_WIDTH + 2,
   localparam int unsigned ADDR_W = $clog2(DEPTH),
   localparam int unsigned JOB_W  = 4 * ADDR_W + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   restart,
   input  wire logic [10:0]            image_width,
   input  wire logic [15:0]            image_height,
   input  wire logic [2:0]             channel_count,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_chan0,
   input  wire logic [7:0]             req_chan1,
   input  wire logic [7:0]             req_chan2,
   input  wire logic                   req_drain,
   input  nmfl_pkg::queue_status_type  qstat,
   input  nmfl_pkg::back_status_type   bstat,
   output logic                        job_push,
   output logic [JOB_W-1:0]            job_data,
   output logic                        mem_we,
   output logic [ADDR_W-1:0]           mem_waddr,
   output logic [15:0]                 mem_wdata
);
   import nmfl_pkg::*;

   localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned M_W    = $clog2(DEPTH + 1);
   localparam int unsigned PEND_W = $clog2(MAX_WIDTH + 3);

   localparam logic [2:0] CH_NONE = 3'd0;
   localparam logic [2:0] CH_GREY = 3'd1;
   localparam logic [2:0] CH_PAIR = 3'd2;

   function automatic logic [M_W-1:0] wrap_sub(input logic [M_W-1:0] x,
                                               input logic [M_W-1:0] d,
                                               input logic [M_W-1:0] md);
      logic [M_W:0] s;
      if (x >= d) s = {1'b0, x} - {1'b0, d};
      else s = {1'b0, x} + {1'b0, md} - {1'b0, d};
      return s[M_W-1:0];
   endfunction

   function automatic logic [M_W-1:0] wrap_add(input logic [M_W-1:0] x,
                                               input logic [M_W-1:0] d,
                                               input logic [M_W-1:0] md);
      logic [M_W:0] s;
      s = {1'b0, x} + {1'b0, d};
      if (s >= {1'b0, md}) s = s - {1'b0, md};
      return s[M_W-1:0];
   endfunction

   logic [ADDR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic [WID_W-1:0]  in_col_ff, in_col_in;
   logic [15:0]       in_row_ff, in_row_in;
   logic [WID_W-1:0]  out_col_ff, out_col_in;
   logic [15:0]       out_row_ff, out_row_in;
   logic              in_done_ff, in_done_in;

   logic [WID_W-1:0]  wid;
   logic [15:0]       hgt;
   logic [M_W-1:0]    md;
   logic [15:0]       luma;
   logic [8:0]        pair_sum;
   logic [23:0]       rgb_sum;
   logic              writes, accept, emit, do_emit, do_write;
   logic [PEND_W:0]   pend_inc;
   logic [M_W-1:0]    base, addr_l, addr_r, addr_t, addr_b, wr_next;
   logic              has_right, has_below, frame_last;
   logic [WID_W:0]    in_col_inc, out_col_inc;
   logic [16:0]       in_row_inc, out_row_inc;

   // effective geometry
   always_comb begin
      if (image_width == 11'd0) wid = WID_W'(1);
      else if (32'(image_width) > 32'(MAX_WIDTH)) wid = WID_W'(MAX_WIDTH);
      else wid = WID_W'(image_width);
      hgt = (image_height == 16'd0) ? 16'd1 : image_height;
      md  = (M_W'(wid) << 1) + M_W'(2);
   end

   // Q8.8 luminance
   always_comb begin
      pair_sum = {1'b0, req_chan0} + {1'b0, req_chan1};
      rgb_sum  = 24'(19595) * 24'(req_chan0) + 24'(38470) * 24'(req_chan1)
               + 24'(7471) * 24'(req_chan2);
      case (channel_count)
         CH_NONE: luma = 16'd0;
         CH_GREY: luma = {req_chan0, 8'd0};
         CH_PAIR: luma = {pair_sum, 7'd0};
         default: luma = rgb_sum[23:8];
      endcase
   end

   // pixel writes only once the back end has its neighbours in hand
   assign writes    = !req_drain && !in_done_ff;
   assign req_stall = writes ? (qstat.full || !qstat.empty || bstat.reading) : qstat.full;
   assign accept    = req_valid && !req_stall;

   assign pend_inc = {1'b0, pending_ff} + (PEND_W+1)'(1);
   always_comb begin
      if (writes) emit = (M_W'(pend_inc) >= M_W'(wid) + M_W'(2));
      else emit = !req_drain ? 1'b0 : (in_done_ff && (pending_ff != '0));
   end
   assign do_emit  = accept && emit;
   assign do_write = accept && writes;

   // neighbour addresses, clamped at frame edges
   assign out_col_inc = {1'b0, out_col_ff} + (WID_W+1)'(1);
   assign out_row_inc = {1'b0, out_row_ff} + 17'd1;
   assign has_right   = out_col_inc < {1'b0, wid};
   assign has_below   = out_row_inc < {1'b0, hgt};
   assign frame_last  = !has_right && !has_below;

   always_comb begin
      base   = wrap_sub(M_W'(wr_pos_ff), M_W'(pending_ff), md);
      addr_l = (out_col_ff != '0) ? wrap_sub(base, M_W'(1), md) : base;
      addr_r = has_right ? wrap_add(base, M_W'(1), md) : base;
      addr_t = (out_row_ff != 16'd0) ? wrap_sub(base, M_W'(wid), md) : base;
      addr_b = has_below ? wrap_add(base, M_W'(wid), md) : base;
      wr_next = wrap_add(M_W'(wr_pos_ff), M_W'(1), md);
   end

   assign job_push = do_emit;
   assign job_data = {frame_last, addr_l[ADDR_W-1:0], addr_r[ADDR_W-1:0],
                      addr_t[ADDR_W-1:0], addr_b[ADDR_W-1:0]};
   assign mem_we    = do_write;
   assign mem_waddr = wr_pos_ff;
   assign mem_wdata = luma;

   assign in_col_inc = {1'b0, in_col_ff} + (WID_W+1)'(1);
   assign in_row_inc = {1'b0, in_row_ff} + 17'd1;

   always_comb begin
      wr_pos_in  = wr_pos_ff;
      pending_in = pending_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      in_done_in = in_done_ff;
      if (do_write) begin
         wr_pos_in = wr_next[ADDR_W-1:0];
         if (in_col_inc >= {1'b0, wid}) begin
            in_col_in = '0;
            in_row_in = in_row_inc[15:0];
            if (in_row_inc >= {1'b0, hgt}) in_done_in = 1'b1;
         end else begin
            in_col_in = in_col_inc[WID_W-1:0];
         end
      end
      if (do_write && !do_emit) pending_in = pend_inc[PEND_W-1:0];
      else if (!do_write && do_emit) pending_in = pending_ff - PEND_W'(1);
      if (do_emit) begin
         if (!has_right) begin
            out_col_in = '0;
            out_row_in = out_row_inc[15:0];
         end else begin
            out_col_in = out_col_inc[WID_W-1:0];
         end
      end
      if ((do_emit && frame_last) || restart) begin
         wr_pos_in  = '0;
         pending_in = '0;
         in_col_in  = '0;
         in_row_in  = 16'd0;
         out_col_in = '0;
         out_row_in = 16'd0;
         in_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff  <= '0;
         pending_ff <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= 16'd0;
         out_col_ff <= '0;
         out_row_ff <= 16'd0;
         in_done_ff <= 1'b0;
      end else begin
         wr_pos_ff  <= wr_pos_in;
         pending_ff <= pending_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         in_done_ff <= in_done_in;
      end
   end

endmodule
`default_nettype wire

@@ src/nmfl_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nmfl_back #(
   parameter int unsigned MAX_WIDTH = nmfl_pkg::MAX_WIDTH_DEFAULT,
   localparam int unsigned DEPTH  = 2 * MAX_WIDTH + 2,
   localparam int unsigned ADDR_W = $clog2(DEPTH),
   localparam int unsigned JOB_W  = 4 * ADDR_W + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   mem_we,
   input  wire logic [ADDR_W-1:0]      mem_waddr,
   input  wire logic [15:0]            mem_wdata,
   input  nmfl_pkg::queue_status_type  qstat,
   input  wire logic [JOB_W-1:0]       job_data,
   output logic                        job_pop,
   output nmfl_pkg::back_status_type   bstat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_normal_x,
   output logic [7:0]                  rsp_normal_y,
   output logic [7:0]                  rsp_normal_z,
   output logic                        rsp_frame_end
);
   import nmfl_pkg::*;

   localparam logic [1:0]  COMP_X = 2'd0;
   localparam logic [1:0]  COMP_Y = 2'd1;
   localparam logic [1:0]  COMP_Z = 2'd2;
   localparam logic [15:0] SCALE  = 16'd65025;   // 255^2
   localparam logic [33:0] Q_BIAS = 34'd262144;  // 512^2
   localparam logic [2:0]  RD_LAST = 3'd4;

   logic [15:0] luma_mem [DEPTH];
   logic [15:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   back_state_type state_ff, state_in;
   logic [JOB_W-1:0] job_ff;
   logic [2:0]  rd_idx_ff;
   logic [15:0] lum_l_ff, lum_r_ff, lum_t_ff, lum_b_ff;
   logic        neg_x_ff, neg_y_ff;
   logic [15:0] mag_x_ff, mag_y_ff;
   logic [31:0] sq_x_ff, sq_y_ff;
   logic [33:0] q_ff;
   logic [1:0]  comp_ff;
   logic [31:0] rp0_ff, rp1_ff;
   logic        a_neg_ff, a_zero_ff;
   logic [47:0] rhs_ff;
   logic [7:0]  res_ff, trial_ff;
   logic [2:0]  bit_ff;
   logic        kneg_ff;
   logic [15:0] ksq_ff;
   logic [32:0] lp0_ff, lp1_ff;
   logic [7:0]  nx_ff, ny_ff, nz_ff;
   logic [7:0]  res_x_ff, res_y_ff, res_z_ff;
   logic        rsp_valid_ff, frame_end_ff;

   logic [16:0] diff_x, diff_y;
   logic [15:0] mag_x, mag_y;
   logic [31:0] a2_sel;
   logic        neg_sel, zero_sel;
   logic [7:0]  trial;
   logic [8:0]  k_raw;
   logic [7:0]  k_mag;
   logic [49:0] lhs;
   logic        ok;
   logic [7:0]  res_next;
   logic        out_free, load_out;

   // line store
   always_ff @(posedge clock) begin
      if (mem_we) luma_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= luma_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:    if (!qstat.empty) state_in = B_READ;
         B_READ:    if (rd_idx_ff == RD_LAST) state_in = B_SQUARE;
         B_SQUARE:  state_in = B_SUM;
         B_SUM:     state_in = B_RHS;
         B_RHS:     state_in = B_RHS_SUM;
         B_RHS_SUM: state_in = B_K;
         B_K:       state_in = B_MUL;
         B_MUL:     state_in = B_CMP;
         B_CMP: begin
            if (bit_ff != 3'd0) state_in = B_K;
            else if (comp_ff == COMP_Z) state_in = B_OUT;
            else state_in = B_RHS;
         end
         B_OUT:     if (out_free) state_in = B_IDLE;
         default:   state_in = B_IDLE;
      endcase
   end

   // control outputs
   assign out_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      job_pop       = (state_ff == B_IDLE) && !qstat.empty;
      bstat.reading = (state_ff == B_READ);
      load_out      = (state_ff == B_OUT) && out_free;
      case (rd_idx_ff)
         3'd0:    rd_addr = job_ff[4*ADDR_W-1:3*ADDR_W];
         3'd1:    rd_addr = job_ff[3*ADDR_W-1:2*ADDR_W];
         3'd2:    rd_addr = job_ff[2*ADDR_W-1:ADDR_W];
         default: rd_addr = job_ff[ADDR_W-1:0];
      endcase
   end

   // datapath
   always_comb begin
      diff_x = {1'b0, lum_r_ff} - {1'b0, lum_l_ff};
      diff_y = {1'b0, lum_b_ff} - {1'b0, lum_t_ff};
      mag_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
      mag_y  = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
      case (comp_ff)
         COMP_X: begin
            a2_sel = sq_x_ff; neg_sel = neg_x_ff; zero_sel = (mag_x_ff == 16'd0);
         end
         COMP_Y: begin
            a2_sel = sq_y_ff; neg_sel = neg_y_ff; zero_sel = (mag_y_ff == 16'd0);
         end
         default: begin
            a2_sel = Q_BIAS[31:0]; neg_sel = 1'b1; zero_sel = 1'b0;
         end
      endcase
      trial = res_ff | (8'd1 << bit_ff);
      k_raw = trial[7] ? ({trial, 1'b0} - 9'd255) : (9'd255 - {trial, 1'b0});
      k_mag = k_raw[7:0];
      lhs   = {lp1_ff, 17'd0} + {17'd0, lp0_ff};
      // largest n with (255-2n)*sqrt(q) >= 255*a, by squares
      if (!kneg_ff) ok = a_neg_ff || a_zero_ff || (lhs >= {2'd0, rhs_ff});
      else ok = a_neg_ff && (lhs <= {2'd0, rhs_ff});
      res_next = ok ? trial_ff : res_ff;
   end

   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job_data;
      if (state_ff == B_READ) begin
         case (rd_idx_ff)
            3'd1:    lum_l_ff <= rd_data_ff;
            3'd2:    lum_r_ff <= rd_data_ff;
            3'd3:    lum_t_ff <= rd_data_ff;
            RD_LAST: lum_b_ff <= rd_data_ff;
            default: begin
            end
         endcase
      end
      if (state_ff == B_SQUARE) begin
         neg_x_ff <= diff_x[16];
         neg_y_ff <= diff_y[16];
         mag_x_ff <= mag_x;
         mag_y_ff <= mag_y;
         sq_x_ff  <= 32'(mag_x) * 32'(mag_x);
         sq_y_ff  <= 32'(mag_y) * 32'(mag_y);
      end
      if (state_ff == B_SUM) q_ff <= 34'(sq_x_ff) + 34'(sq_y_ff) + Q_BIAS;
      if (state_ff == B_RHS) begin
         rp0_ff    <= 32'(SCALE) * 32'(a2_sel[15:0]);
         rp1_ff    <= 32'(SCALE) * 32'(a2_sel[31:16]);
         a_neg_ff  <= neg_sel;
         a_zero_ff <= zero_sel;
      end
      if (state_ff == B_RHS_SUM) begin
         rhs_ff <= {rp1_ff, 16'd0} + {16'd0, rp0_ff};
         res_ff <= 8'd0;
         bit_ff <= 3'd7;
      end
      if (state_ff == B_K) begin
         trial_ff <= trial;
         kneg_ff  <= trial[7];
         ksq_ff   <= 16'(k_mag) * 16'(k_mag);
      end
      if (state_ff == B_MUL) begin
         lp0_ff <= 33'(ksq_ff) * 33'(q_ff[16:0]);
         lp1_ff <= 33'(ksq_ff) * 33'(q_ff[33:17]);
      end
      if (state_ff == B_CMP) begin
         res_ff <= res_next;
         bit_ff <= bit_ff - 3'd1;
         if (bit_ff == 3'd0) begin
            case (comp_ff)
               COMP_X:  res_x_ff <= res_next;
               COMP_Y:  res_y_ff <= res_next;
               default: res_z_ff <= res_next;
            endcase
         end
      end
      if (load_out) begin
         nx_ff        <= res_x_ff;
         ny_ff        <= res_y_ff;
         nz_ff        <= res_z_ff;
         frame_end_ff <= job_ff[JOB_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_idx_ff    <= 3'd0;
         comp_ff      <= COMP_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_READ) rd_idx_ff <= rd_idx_ff + 3'd1;
         else rd_idx_ff <= 3'd0;
         if (state_ff == B_SUM) comp_ff <= COMP_X;
         else if (state_ff == B_CMP && bit_ff == 3'd0 && comp_ff != COMP_Z)
            comp_ff <= comp_ff + 2'd1;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_normal_x  = nx_ff;
   assign rsp_normal_y  = ny_ff;
   assign rsp_normal_z  = nz_ff;
   assign rsp_frame_end = frame_end_ff;

`ifndef SYNTHESIS
   a_pop_starts_read: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == B_READ) && (rd_idx_ff == 3'd0))
      else $error("popped request did not start neighbour reads");
   a_last_comp_outputs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CMP) && (bit_ff == 3'd0) && (comp_ff == COMP_Z) |=> state_ff == B_OUT)
      else $error("search did not finish into output stage");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT) && rsp_valid_ff && rsp_stall |=> state_ff == B_OUT)
      else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire
